/* src/spq_pkg.sv */
package spq_pkg;

  localparam int unsigned ValW    = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 5;

  localparam logic FuncEnq = 1'b0;
  localparam logic FuncDeq = 1'b1;

  localparam logic [StatusW-1:0] StatusOk        = 2'd0;
  localparam logic [StatusW-1:0] StatusOverflow  = 2'd1;
  localparam logic [StatusW-1:0] StatusUnderflow = 2'd2;

  typedef struct packed {
    logic                   func;
    logic signed [ValW-1:0] value;
  } spq_in_t;

  typedef struct packed {
    logic [StatusW-1:0]     status;
    logic signed [ValW-1:0] removed_value;
    logic [CountW-1:0]      count;
  } spq_out_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic                   enq;
    logic                   deq;
    logic signed [ValW-1:0] value;
  } spq_ctrl_t;

endpackage

/* src/sorted_array_priority_queue.sv */
// channel   | ports                   | transaction
// ----------+-------------------------+-------------------------------------------
// command   | start, busy, cmd_i      | accepted on clk edge with start && !busy
// result    | done_o, res_o           | one cycle strobe, no back pressure
//
// every command's result shows on res_o with done_o in the cycle after
// acceptance, and busy stays low so a command can enter every cycle, since
// all cells of the chain compare and shift at once
// reset clears the fill count and the result strobe; cell contents are not reset
// the receiver cannot stall, so results are never held back
module sorted_array_priority_queue
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  spq_in_t  cmd_i,
  output logic     done_o,
  output spq_out_t res_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0] count_q, count_d;
  logic            done_q;
  spq_out_t        res_q, res_d;
  logic            accept;
  logic            full, empty;
  spq_ctrl_t       ctrl;

  logic signed [ValW-1:0] cell_val [DEPTH];
  logic                   cell_ge  [DEPTH];

  // busy is tied low, never stalls the sender
  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_q == CntW'(DEPTH));
  assign empty  = (count_q == '0);

  assign ctrl.enq   = accept && (cmd_i.func == FuncEnq) && !full;
  assign ctrl.deq   = accept && (cmd_i.func == FuncDeq) && !empty;
  assign ctrl.value = cmd_i.value;

  // chain of cells, head at index zero
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [ValW-1:0] left_val, right_val;
    logic                   left_ge;
    logic                   occ;

    assign occ = (CntW'(i) < count_q);

    if (i == 0) begin : g_head
      assign left_val = '0;
      assign left_ge  = 1'b0;
    end else begin : g_body
      assign left_val = cell_val[i-1];
      assign left_ge  = cell_ge[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_val = '0;
    end else begin : g_mid
      assign right_val = cell_val[i+1];
    end

    spq_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .first_i    (i == 0),
      .occ_i      (occ),
      .left_val_i (left_val),
      .left_ge_i  (left_ge),
      .right_val_i(right_val),
      .val_o      (cell_val[i]),
      .ge_o       (cell_ge[i])
    );
  end

  // fill count and result for the accepted transaction
  always_comb begin
    count_d             = count_q;
    res_d               = res_q;
    if (accept) begin
      res_d.status        = StatusOk;
      res_d.removed_value = '0;
      if (cmd_i.func == FuncEnq) begin
        if (full) begin
          res_d.status = StatusOverflow;
        end else begin
          count_d = count_q + 1'b1;
        end
      end else begin
        if (empty) begin
          res_d.status = StatusUnderflow;
        end else begin
          res_d.removed_value = cell_val[0];
          count_d             = count_q - 1'b1;
        end
      end
      // count port keeps only its low bits for wide depths
      res_d.count = CountW'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

/* src/spq_cell.sv */
module spq_cell
  import spq_pkg::*;
(
  input  logic                   clk_i,
  input  spq_ctrl_t              ctrl_i,
  input  logic                   first_i,
  input  logic                   occ_i,
  input  logic signed [ValW-1:0] left_val_i,
  input  logic                   left_ge_i,
  input  logic signed [ValW-1:0] right_val_i,
  output logic signed [ValW-1:0] val_o,
  output logic                   ge_o
);

  logic signed [ValW-1:0] val_q, val_d;

  // held value stays ahead of an equal newcomer
  assign ge_o  = occ_i && (val_q >= ctrl_i.value);
  assign val_o = val_q;

  always_comb begin
    val_d = val_q;
    if (ctrl_i.enq) begin
      if (!ge_o) begin
        if (first_i || left_ge_i) begin
          val_d = ctrl_i.value;
        end else begin
          val_d = left_val_i;
        end
      end
    end else if (ctrl_i.deq) begin
      val_d = right_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

/* tb/sv/testbench.sv */
module testbench;
  import spq_pkg::*;

  localparam int unsigned DEPTH     = 16;
  // the longest sender gap is far shorter, so this only trips on a hang
  localparam int unsigned IdleLimit = 500;
  localparam int unsigned RandItems = 950;

  // one row of the directed table; the typed result is used only where it
  // is obvious, every other row takes the predicted one
  typedef struct {
    spq_in_t  cmd;
    bit       typed;
    spq_out_t want;
  } step_row_t;

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     start;
  logic     busy;
  spq_in_t  cmd_i;
  logic     done_o;
  spq_out_t res_o;

  // predictor state: sorted copy of the queue, largest first
  logic signed [ValW-1:0] held_vals [DEPTH];
  int unsigned            held_count;

  // results still owed by the block, oldest first
  spq_out_t    pending_results[$];
  step_row_t   directed_rows[$];
  int unsigned mismatches;
  int unsigned idle_cycles;

  sorted_array_priority_queue #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .cmd_i (cmd_i),
    .done_o(done_o),
    .res_o (res_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // apply one command to the shadow queue and return what the block must report
  function automatic spq_out_t apply_to_queue(spq_in_t c);
    spq_out_t r;
    int       pos;
    r = '0;
    r.status = StatusOk;
    if (c.func == FuncEnq) begin
      if (held_count >= DEPTH) begin
        r.status = StatusOverflow;
      end else begin
        // new value goes behind every held value that is greater or equal
        pos = held_count;
        while (pos > 0 && $signed(held_vals[pos-1]) < $signed(c.value)) begin
          held_vals[pos] = held_vals[pos-1];
          pos--;
        end
        held_vals[pos] = c.value;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        r.status = StatusUnderflow;
      end else begin
        r.removed_value = held_vals[0];
        for (int k = 0; k + 1 < held_count; k++) held_vals[k] = held_vals[k+1];
        held_count--;
      end
    end
    r.count = CountW'(held_count);
    return r;
  endfunction

  function automatic void add_row(logic f, logic [ValW-1:0] v, bit typed = 1'b0,
                                  logic [StatusW-1:0] st = StatusOk,
                                  logic [ValW-1:0] rm = '0,
                                  logic [CountW-1:0] cnt = '0);
    step_row_t row;
    row.cmd.func   = f;
    row.cmd.value  = v;
    row.typed      = typed;
    row.want       = '0;
    row.want.status        = st;
    row.want.removed_value = rm;
    row.want.count         = cnt;
    directed_rows.push_back(row);
  endfunction

  // value mix: full range, a narrow band so equal values pile up, and the extremes
  function automatic logic [ValW-1:0] pick_value();
    logic [ValW-1:0] v;
    case ($urandom_range(0, 3))
      0, 1: v = $urandom;
      2:    v = ValW'($urandom_range(0, 8)) - ValW'(4);
      default: begin
        case ($urandom_range(0, 4))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'h0000_0000;
          3: v = 32'hFFFF_FFFF;
          default: v = 32'h0000_0001;
        endcase
      end
    endcase
    return v;
  endfunction

  // drive one command after an idle gap, hold it until the block takes it
  task automatic send_cmd(spq_in_t c, bit typed, spq_out_t want, int unsigned gap);
    spq_out_t predicted;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy);
    // transaction taken at this edge
    predicted = apply_to_queue(c);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // stop sending and wait until every owed result has shown up
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // result checker, also feeds the watchdog
  always @(posedge clk_i) begin
    spq_out_t want;
    if (rst_ni && ((start && !busy) || done_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, got %p", $time, res_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (res_o.status !== want.status) begin
          $display("%0t: status mismatch: expected %0d, got %0d",
                   $time, want.status, res_o.status);
          mismatches++;
        end
        if (res_o.removed_value !== want.removed_value) begin
          $display("%0t: removed_value mismatch: expected %0d, got %0d",
                   $time, want.removed_value, res_o.removed_value);
          mismatches++;
        end
        if (res_o.count !== want.count) begin
          $display("%0t: count mismatch: expected %0d, got %0d",
                   $time, want.count, res_o.count);
          mismatches++;
        end
      end
    end
  end

  // watchdog: too long with no transaction on either side ends the run
  initial begin
    wait (rst_ni === 1'b1);
    while (idle_cycles < IdleLimit) @(posedge clk_i);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    spq_in_t     c;
    spq_out_t    none;
    int unsigned sent;
    int unsigned phase_len;
    int unsigned enq_pct;
    int unsigned gap_mode;
    int unsigned gap;

    rst_ni      = 1'b0;
    start       = 1'b0;
    cmd_i       = '0;
    mismatches  = 0;
    idle_cycles = 0;
    held_count  = 0;
    none        = '0;

    // directed part: empty dequeue, both extremes, equal values, fill to
    // full, full enqueue, then take the head back off
    add_row(FuncDeq, 32'h0000_0000, 1'b1, StatusUnderflow, '0, 5'd0);
    add_row(FuncEnq, 32'h7FFF_FFFF, 1'b1, StatusOk, '0, 5'd1);
    add_row(FuncEnq, 32'h8000_0000, 1'b1, StatusOk, '0, 5'd2);
    add_row(FuncEnq, 32'h0000_0000);
    add_row(FuncEnq, 32'hFFFF_FFFF);
    add_row(FuncEnq, 32'h0000_0005);
    add_row(FuncEnq, 32'h0000_0005);
    add_row(FuncEnq, 32'h0000_0005);
    add_row(FuncDeq, 32'hFFFF_FFFF, 1'b1, StatusOk, 32'h7FFF_FFFF, 5'd6);
    add_row(FuncDeq, 32'h0000_0000);
    add_row(FuncEnq, 32'h5555_5555);
    add_row(FuncEnq, 32'hAAAA_AAAA);
    add_row(FuncEnq, 32'h0000_0001);
    add_row(FuncEnq, 32'hFFFF_FFFE);
    add_row(FuncEnq, 32'h4000_0000);
    add_row(FuncEnq, 32'h8000_0000);
    add_row(FuncEnq, 32'h7FFF_FFFF);
    add_row(FuncEnq, 32'h0000_0064);
    add_row(FuncEnq, 32'hFFFF_FF9C);
    add_row(FuncEnq, 32'h1234_5678);
    add_row(FuncEnq, 32'hFEDC_BA98);
    add_row(FuncEnq, 32'h0000_0000, 1'b1, StatusOverflow, '0, 5'd16);
    add_row(FuncDeq, 32'h0000_0000, 1'b1, StatusOk, 32'h7FFF_FFFF, 5'd15);
    add_row(FuncDeq, 32'h0000_0000);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_cmd(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want,
               $urandom_range(0, 11));

    // sender holds off until the queue of owed results is empty
    wait_drained();

    // random part in phases: fill-heavy, drain-heavy or balanced, each with its
    // own idle pattern so gaps land on full, empty and part-filled queues alike
    sent = 0;
    while (sent < RandItems) begin
      phase_len = $urandom_range(20, 80);
      case ($urandom_range(0, 2))
        0:       enq_pct = 85;
        1:       enq_pct = 15;
        default: enq_pct = 50;
      endcase
      gap_mode = $urandom_range(0, 2);
      for (int n = 0; n < phase_len && sent < RandItems; n++) begin
        c.func  = ($urandom_range(0, 99) < enq_pct) ? FuncEnq : FuncDeq;
        c.value = pick_value();
        case (gap_mode)
          0:       gap = 0;
          1:       gap = $urandom_range(0, 11);
          default: gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
        endcase
        send_cmd(c, 1'b0, none, gap);
        sent++;
      end
      if ($urandom_range(0, 3) == 0) wait_drained();
    end

    wait_drained();
    repeat (4) @(posedge clk_i);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
